// ----- hw/rtl/vum_pkg.sv -----
// Shared constants, types and the LED ramp table for the VU meter bar.
// No dependencies; every other file in hw/rtl imports this package.
package vum_pkg;

	localparam int LINES_PER_FRAME  = 240;
	localparam int SAMPLES_PER_LINE = 4;
	localparam int FRAME_LEN        = LINES_PER_FRAME * SAMPLES_PER_LINE;

	localparam int SAMPLE_W = 16;
	localparam int MAG_W    = SAMPLE_W + 1;
	localparam int SUM_W    = $clog2(FRAME_LEN * 32768 + 1);
	localparam int CNT_W    = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;
	localparam int DIV_W    = $clog2(FRAME_LEN + 1);

	// mean = (sum * RECIP) >> RECIP_SH, exact for every sum below 2^SUM_W
	localparam int              RECIP_SH = SUM_W + DIV_W;
	localparam int              RECIP_W  = SUM_W + 2;
	localparam int              MPROD_W  = SUM_W + RECIP_W;
	localparam longint unsigned RECIP    =
		((64'd1 << RECIP_SH) + 64'(FRAME_LEN) - 64'd1) / 64'(FRAME_LEN);

	localparam int MEAN_W  = 16;
	localparam int FRAC_W  = 16;
	localparam int PEAK_W  = 32;
	localparam int DECAY_W = 16;
	localparam int PROD_W  = PEAK_W + DECAY_W;
	localparam int LHS_W   = MEAN_W + 3 + FRAC_W;

	localparam int BAR_LEDS = 5;
	localparam int LED_W    = 3;
	localparam int PIXEL_W  = 24;

	localparam logic [PEAK_W-1:0]  PEAK_RESET  = 32'h07D0_0000;
	localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd65208;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic             valid;
		logic [SUM_W-1:0] sum;
	} frame_push_t;

	typedef struct packed {
		logic             valid;
		logic [SUM_W-1:0] sum;
	} frame_head_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_DIV,
		B_PEAK,
		B_DECAY,
		B_LEVEL,
		B_EMIT
	} back_state_t;

	// LED ramp, index 0 is the bottom LED
	function automatic logic [PIXEL_W-1:0] ramp_grb(input logic [LED_W-1:0] led);
		logic [PIXEL_W-1:0] c;
		case (led)
			3'd0:    c = 24'hFF0000;
			3'd1:    c = 24'hBF4000;
			3'd2:    c = 24'h808000;
			3'd3:    c = 24'h40BF00;
			3'd4:    c = 24'h00FF00;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

// ----- hw/rtl/vum_front.sv -----
// Front end: takes samples, accumulates magnitudes, pushes one sum per frame.
// Depends on vum_pkg.
module vum_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [vum_pkg::SAMPLE_W-1:0] sample,
	input  logic                        queue_full,
	output vum_pkg::frame_push_t        push
);
	import vum_pkg::*;

	logic             accept;
	logic [MAG_W-1:0] sample_ext;
	logic [MAG_W-1:0] mag;
	logic [SUM_W-1:0] sum_next;
	logic             frame_end;
	logic [SUM_W-1:0] abs_sum_q;
	logic [CNT_W-1:0] count_q;

	assign in_stall   = queue_full;
	assign accept     = in_valid && !queue_full;
	assign sample_ext = {sample[SAMPLE_W-1], sample};
	// most negative sample comes out as 32768
	assign mag        = sample[SAMPLE_W-1] ? (MAG_W'(0) - sample_ext) : sample_ext;
	assign sum_next   = abs_sum_q + SUM_W'(mag);
	assign frame_end  = (count_q == CNT_W'(FRAME_LEN - 1));

	assign push.valid = accept && frame_end;
	assign push.sum   = sum_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			abs_sum_q <= '0;
			count_q   <= '0;
		end else if (accept) begin
			if (frame_end) begin
				abs_sum_q <= '0;
				count_q   <= '0;
			end else begin
				abs_sum_q <= sum_next;
				count_q   <= count_q + CNT_W'(1);
			end
		end
	end

endmodule

// ----- hw/rtl/vum_queue.sv -----
// Short queue of frame sums between the front end and the back end.
// Depends on vum_pkg.
module vum_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  vum_pkg::frame_push_t push,
	input  logic                 pop,
	output vum_pkg::frame_head_t head,
	output logic                 full
);
	import vum_pkg::*;

	logic [SUM_W-1:0]  mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.sum   = mem_q[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !full)
		else $error("frame sum pushed into a full queue");
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("pop from an empty queue");
`endif

endmodule

// ----- hw/rtl/vum_back.sv -----
// Back end: mean by reciprocal multiplication, peak update and decay, bar level,
// then five pixels through an output register. Depends on vum_pkg.
module vum_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  vum_pkg::frame_head_t         head,
	output logic                         pop,
	input  logic [vum_pkg::DECAY_W-1:0]  decay_q16,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [vum_pkg::PIXEL_W-1:0]  led_grb,
	output logic                         is_last
);
	import vum_pkg::*;

	back_state_t        state_q;
	back_state_t        state_nxt;
	logic [SUM_W-1:0]   sum_q;
	logic [MEAN_W-1:0]  mean_q;
	logic [PEAK_W-1:0]  peak_q;
	logic [PROD_W-1:0]  prod_q;
	logic [LHS_W-1:0]   kpeak_q;
	logic [LED_W-1:0]   k_q;
	logic [LED_W-1:0]   level_q;
	logic [LED_W-1:0]   pix_idx_q;
	logic               out_valid_q;
	logic [PIXEL_W-1:0] pixel_q;
	logic               last_q;

	logic [MPROD_W-1:0] quot_prod;
	logic [MEAN_W-1:0]  mean;
	logic [PEAK_W-1:0]  mean_ext;
	logic               mean_wins;
	logic [LHS_W-1:0]   lhs;
	logic [LED_W-1:0]   led;
	logic               level_done;
	logic               out_load;
	logic               emit;
	logic               emit_last;

	// sum / FRAME_LEN; the quotient never exceeds 32768
	assign quot_prod = sum_q * RECIP_W'(RECIP);
	assign mean      = mean_q;
	assign mean_ext  = {mean, FRAC_W'(0)};
	assign mean_wins = (mean_ext > peak_q);
	assign lhs       = {(MEAN_W+3)'(mean) * (MEAN_W+3)'(BAR_LEDS), FRAC_W'(0)};
	assign led       = LED_W'(BAR_LEDS - 1) - pix_idx_q;

	// control outputs
	always_comb begin
		pop        = 1'b0;
		level_done = (k_q == LED_W'(BAR_LEDS));
		out_load   = !out_valid_q || !out_stall;
		emit       = 1'b0;
		emit_last  = 1'b0;
		case (state_q)
			B_IDLE: begin
				pop = head.valid;
			end
			B_EMIT: begin
				emit      = out_load;
				emit_last = out_load && (pix_idx_q == LED_W'(BAR_LEDS - 1));
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			B_IDLE: begin
				if (head.valid) state_nxt = B_DIV;
			end
			B_DIV: begin
				state_nxt = B_PEAK;
			end
			B_PEAK: begin
				state_nxt = mean_wins ? B_LEVEL : B_DECAY;
			end
			B_DECAY: begin
				state_nxt = B_LEVEL;
			end
			B_LEVEL: begin
				if (level_done) state_nxt = B_EMIT;
			end
			B_EMIT: begin
				if (emit_last) state_nxt = B_IDLE;
			end
			default: begin
				state_nxt = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			peak_q      <= PEAK_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == B_PEAK && mean_wins) begin
				peak_q <= mean_ext;
			end else if (state_q == B_DECAY) begin
				peak_q <= prod_q[PROD_W-1:DECAY_W];
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (pop) begin
					sum_q <= head.sum;
				end
			end
			B_DIV: begin
				mean_q <= quot_prod[RECIP_SH +: MEAN_W];
			end
			B_PEAK: begin
				prod_q  <= peak_q * decay_q16;
				kpeak_q <= LHS_W'(mean_ext);
				k_q     <= LED_W'(1);
				level_q <= '0;
			end
			B_DECAY: begin
				kpeak_q <= LHS_W'(prod_q[PROD_W-1:DECAY_W]);
			end
			B_LEVEL: begin
				// zero peak leaves the level at 0
				if (peak_q != '0 && lhs >= kpeak_q) begin
					level_q <= k_q;
				end
				kpeak_q   <= kpeak_q + LHS_W'(peak_q);
				k_q       <= k_q + LED_W'(1);
				pix_idx_q <= '0;
			end
			B_EMIT: begin
				if (emit) begin
					pixel_q   <= (led < level_q) ? ramp_grb(led) : '0;
					last_q    <= emit_last;
					pix_idx_q <= pix_idx_q + LED_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign led_grb   = pixel_q;
	assign is_last   = last_q;

`ifndef SYNTHESIS
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_EMIT) |-> (level_q <= LED_W'(BAR_LEDS)))
		else $error("bar level out of range");
	a_zero_peak: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_EMIT && peak_q == '0) |-> (level_q == '0))
		else $error("zero peak gave a non-zero level");
	a_peak_take: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_PEAK && mean_wins) |=> (peak_q == $past(mean_ext)))
		else $error("peak not replaced by a larger mean");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		emit_last |=> (state_q == B_IDLE && is_last && out_valid))
		else $error("fifth pixel not flagged or run not closed");
`endif

endmodule

// ----- hw/rtl/vu_meter_peak_tracking_bar_top.sv -----
// VU meter bar, top level: decay register, front end, frame queue, back end.
// Depends on vum_pkg, vum_front, vum_queue and vum_back.
//
// Samples (signed 16 bit) are taken one per clock with no gaps: in_stall rises
// only when both entries of the frame-sum queue are occupied. Every 960 samples
// (240 lines of 4) the front end hands the sum of magnitudes to the back end,
// which takes the sum from the queue, forms the mean by reciprocal
// multiplication, compares it with the peak while forming the decay product,
// applies the decay when the mean does not beat the peak, searches the bar
// level, then makes five pixel transfers, each of which waits while out_stall
// is high. The pixels come out top LED first, is_last marks the fifth. The
// peak resets to 2000.0 in 16.16 and decays by decay_q16 (Q0.16, reset 65208)
// on each frame whose mean does not beat it. Write decay_q16 with cfg_wr_en and
// cfg_wr_data only while the block is idle; the new value applies from the next
// frame evaluated.
module vu_meter_peak_tracking_bar_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [vum_pkg::DECAY_W-1:0]  cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [vum_pkg::SAMPLE_W-1:0] sample,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [vum_pkg::PIXEL_W-1:0]  led_grb,
	output logic                         is_last
);
	import vum_pkg::*;

	logic [DECAY_W-1:0] decay_q;
	frame_push_t        push;
	frame_head_t        head;
	logic               pop;
	logic               queue_full;

	// decay factor register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q <= DECAY_RESET;
		end else if (cfg_wr_en) begin
			decay_q <= cfg_wr_data;
		end
	end

	vum_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample     (sample),
		.queue_full (queue_full),
		.push       (push)
	);

	vum_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.full   (queue_full)
	);

	vum_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.decay_q16 (decay_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.led_grb   (led_grb),
		.is_last   (is_last)
	);

endmodule
